// ----- sv/wpp_pkg.sv -----
// Shared constants, register codes and pipeline types for the
// world-to-screen projection core. No dependencies.
package wpp_pkg;

  localparam int FracBits    = 16;
  localparam int CoordWidth  = 32;
  localparam int CoefWidth   = 32;
  localparam int SizeWidth   = 14;
  localparam int CfgWidth    = 64;
  localparam int CfgIdxWidth = 3;

  localparam int ProdW = CoefWidth + CoordWidth;
  localparam int BiasW = CoefWidth + FracBits;
  localparam int ClipW = ((ProdW > BiasW) ? ProdW : BiasW) + 2;
  localparam int NumW  = ClipW + SizeWidth + FracBits;
  localparam int DivW  = ClipW + 1;
  localparam int RemW  = DivW + 1;
  // quotient bits kept; anything at or above 2^QBits saturates the coordinate
  localparam int QBits = ((CoordWidth > SizeWidth + FracBits) ?
                          CoordWidth : SizeWidth + FracBits) + 1;
  localparam int SumW  = QBits + 2;
  // products, sums, setup, overflow check, QBits divide steps, output
  localparam int Latency = QBits + 5;

  // smallest clip w with w * 1000 >= 2^(2*FracBits)
  localparam longint unsigned VisMin =
    ((64'd1 << (2 * FracBits)) + 64'd999) / 64'd1000;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgRow0Lo  = 3'd0,
    CfgRow0Hi  = 3'd1,
    CfgRow1Lo  = 3'd2,
    CfgRow1Hi  = 3'd3,
    CfgRowWLo  = 3'd4,
    CfgRowWHi  = 3'd5,
    CfgWidthR  = 3'd6,
    CfgHeightR = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [RemW-1:0]  rem;
    logic [QBits-1:0] num_lo;
    logic [QBits-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic            vis;
    logic [DivW-1:0] den;
    div_lane_t       x;
    div_lane_t       y;
  } div_stage_t;

endpackage

// ----- sv/world_to_screen_projection_core.sv -----
// World-to-screen projection core: matrix rows, visibility test,
// pipelined restoring dividers and viewport mapping. Uses wpp_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  point   | start, point_x/y/z_i (busy is out)        | in
//  result  | result_valid_o, visible_o, screen_x/y_o   | out
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i           | in
//
// One point beat is taken every cycle; busy is never raised.
// Each result follows its start beat through the product, sum and numerator
// registers, the divider setup, the one-bit-per-stage divider and the output register.
// Reset clears all valid bits and loads the register reset values.
// The result side cannot stall, so the pipeline always advances.
module world_to_screen_projection_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [wpp_pkg::CoordWidth-1:0] point_x_i,
  input  logic signed [wpp_pkg::CoordWidth-1:0] point_y_i,
  input  logic signed [wpp_pkg::CoordWidth-1:0] point_z_i,
  output logic                                 result_valid_o,
  output logic                                 visible_o,
  output logic signed [wpp_pkg::CoordWidth-1:0] screen_x_o,
  output logic signed [wpp_pkg::CoordWidth-1:0] screen_y_o,
  input  logic                                 cfg_we_i,
  input  logic [wpp_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [wpp_pkg::CfgWidth-1:0]         cfg_data_i
);
  import wpp_pkg::*;

  // ---------------- configuration registers ----------------
  logic [CfgWidth-1:0]  mat_q [6];
  logic [SizeWidth-1:0] scr_w_q, scr_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) mat_q[i] <= '0;
      scr_w_q <= SizeWidth'(1920);
      scr_h_q <= SizeWidth'(1080);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgRow0Lo:  mat_q[0] <= cfg_data_i;
        CfgRow0Hi:  mat_q[1] <= cfg_data_i;
        CfgRow1Lo:  mat_q[2] <= cfg_data_i;
        CfgRow1Hi:  mat_q[3] <= cfg_data_i;
        CfgRowWLo:  mat_q[4] <= cfg_data_i;
        CfgRowWHi:  mat_q[5] <= cfg_data_i;
        CfgWidthR:  scr_w_q  <= cfg_data_i[SizeWidth-1:0];
        CfgHeightR: scr_h_q  <= cfg_data_i[SizeWidth-1:0];
        default: ;
      endcase
    end
  end

  // coef[r][k]: row r (0 = x, 1 = y, 2 = w), column k
  logic signed [CoefWidth-1:0] coef [3][4];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = mat_q[2*r][CoefWidth-1:0];
      coef[r][1] = mat_q[2*r][2*CoefWidth-1:CoefWidth];
      coef[r][2] = mat_q[2*r+1][CoefWidth-1:0];
      coef[r][3] = mat_q[2*r+1][2*CoefWidth-1:CoefWidth];
    end
  end

  assign busy = 1'b0;

  // ---------------- stage 1: products ----------------
  logic signed [CoordWidth-1:0] pt [3];
  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  logic signed [ProdW-1:0] prod_q [3][3];
  logic signed [BiasW-1:0] bias_q [3];
  logic                    v1_q;

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) prod_q[r][k] <= coef[r][k] * pt[k];
      // column 3 multiplies the implicit 1.0
      bias_q[r] <= {coef[r][3], {FracBits{1'b0}}};
    end
  end

  // ---------------- stage 2: clip sums ----------------
  logic signed [ClipW-1:0] clip_q [3];
  logic                    v2_q;

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      clip_q[r] <= ClipW'(prod_q[r][0]) + ClipW'(prod_q[r][1])
                 + ClipW'(prod_q[r][2]) + ClipW'(bias_q[r]);
    end
  end

  // ---------------- stage 3: visibility, numerators, divisor ----------------
  logic [ClipW-1:0] mag_x, mag_y;
  logic             vis_d;
  assign mag_x = clip_q[0][ClipW-1] ? ClipW'(-clip_q[0]) : ClipW'(clip_q[0]);
  assign mag_y = clip_q[1][ClipW-1] ? ClipW'(-clip_q[1]) : ClipW'(clip_q[1]);
  assign vis_d = !clip_q[2][ClipW-1] &&
                 ($unsigned(clip_q[2]) >= ClipW'(VisMin));

  logic [NumW-1:0] num_x_q, num_y_q;
  logic [DivW-1:0] den3_q;
  logic            vis3_q, neg_x3_q, neg_y3_q, v3_q;

  always_ff @(posedge clk_i) begin
    num_x_q  <= NumW'(mag_x * scr_w_q) << FracBits;
    num_y_q  <= NumW'(mag_y * scr_h_q) << FracBits;
    den3_q   <= {clip_q[2], 1'b0};
    vis3_q   <= vis_d;
    neg_x3_q <= clip_q[0][ClipW-1];
    neg_y3_q <= clip_q[1][ClipW-1];
  end

  // ---------------- stage 4: overflow check, divider setup ----------------
  div_stage_t st_q [QBits+1];
  logic [QBits:0] dv_q;

  function automatic div_lane_t lane_init(logic [NumW-1:0] num, logic [DivW-1:0] den,
                                          logic neg);
    div_lane_t l;
    logic [NumW-1:0] top;
    top      = num >> QBits;
    l.neg    = neg;
    l.ovf    = top >= NumW'(den);
    l.rem    = RemW'(top);
    l.num_lo = num[QBits-1:0];
    l.quo    = '0;
    return l;
  endfunction

  // one restoring step: bring down the next numerator bit
  function automatic div_lane_t lane_step(div_lane_t l, logic [DivW-1:0] den, int pos);
    div_lane_t       o;
    logic [RemW-1:0] trial;
    logic            ge;
    trial = {l.rem[RemW-2:0], l.num_lo[pos]};
    ge    = trial >= {1'b0, den};
    o     = l;
    o.rem = ge ? trial - {1'b0, den} : trial;
    o.quo = {l.quo[QBits-2:0], ge};
    return o;
  endfunction

  always_ff @(posedge clk_i) begin
    st_q[0].vis <= vis3_q;
    st_q[0].den <= den3_q;
    st_q[0].x   <= lane_init(num_x_q, den3_q, neg_x3_q);
    st_q[0].y   <= lane_init(num_y_q, den3_q, neg_y3_q);
  end

  for (genvar j = 0; j < QBits; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      st_q[j+1].vis <= st_q[j].vis;
      st_q[j+1].den <= st_q[j].den;
      st_q[j+1].x   <= lane_step(st_q[j].x, st_q[j].den, QBits - 1 - j);
      st_q[j+1].y   <= lane_step(st_q[j].y, st_q[j].den, QBits - 1 - j);
    end
  end

  // valid bits for stages 1 to 3 and the divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      dv_q <= '0;
    end else begin
      v1_q <= start;
      v2_q <= v1_q;
      v3_q <= v2_q;
      dv_q <= {dv_q[QBits-1:0], v3_q};
    end
  end

  // ---------------- final stage: viewport map and saturation ----------------
  function automatic logic signed [SumW-1:0] signed_q(div_lane_t l);
    logic [QBits-1:0]       q;
    logic signed [SumW-1:0] s;
    q = l.ovf ? '1 : l.quo;    // overflow is far past the saturation point
    s = $signed({2'b00, q});
    return l.neg ? -s : s;
  endfunction

  function automatic logic signed [CoordWidth-1:0] sat(logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi, lo;
    hi = SumW'({1'b0, {(CoordWidth-1){1'b1}}});
    lo = -hi - SumW'(1);
    if (v > hi) return CoordWidth'(hi);
    if (v < lo) return CoordWidth'(lo);
    return CoordWidth'(v);
  endfunction

  div_stage_t             fin;
  logic signed [SumW-1:0] off_x, off_y, sx_d, sy_d;
  assign fin   = st_q[QBits];
  assign off_x = $signed(SumW'(scr_w_q) << (FracBits - 1));
  assign off_y = $signed(SumW'(scr_h_q) << (FracBits - 1));
  assign sx_d  = off_x + signed_q(fin.x);
  assign sy_d  = off_y - signed_q(fin.y);

  logic                         out_v_q, vis_q;
  logic signed [CoordWidth-1:0] sx_q, sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else         out_v_q <= dv_q[QBits];
  end

  always_ff @(posedge clk_i) begin
    vis_q <= fin.vis;
    sx_q  <= fin.vis ? sat(sx_d) : '0;
    sy_q  <= fin.vis ? sat(sy_d) : '0;
  end

  assign result_valid_o = out_v_q;
  assign visible_o      = vis_q;
  assign screen_x_o     = sx_q;
  assign screen_y_o     = sy_q;

endmodule

// ----- sv/wpp_checker.sv -----
// Port-level checks for the projection core, bound to the top level.
// Uses wpp_pkg.
module wpp_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 result_valid_o,
  input logic                                 visible_o,
  input logic signed [wpp_pkg::CoordWidth-1:0] screen_x_o,
  input logic signed [wpp_pkg::CoordWidth-1:0] screen_y_o
);
  import wpp_pkg::*;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy raised");

  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##Latency result_valid_o) else $error("result beat missing");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, Latency)) else $error("result without point");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !visible_o) |-> (screen_x_o == '0 && screen_y_o == '0))
    else $error("hidden point has nonzero coordinates");

endmodule

bind world_to_screen_projection_core wpp_checker u_wpp_checker (
  .clk_i, .rst_ni, .start, .busy, .result_valid_o, .visible_o,
  .screen_x_o, .screen_y_o
);

// ----- bench/world_to_screen_projection_core_test.sv -----
// Self-checking bench for world_to_screen_projection_core: directed and random points
// under several matrix and viewport settings, checked against an in-bench predictor.
// Depends on wpp_pkg and the core RTL.
module world_to_screen_projection_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wpp_pkg::*;

  typedef logic signed [127:0] wide_t;

  // one expected screen-space beat
  typedef struct {
    logic                         vis;
    logic signed [CoordWidth-1:0] sx;
    logic signed [CoordWidth-1:0] sy;
  } screen_pt_t;

  // Holds a private copy of the register file, projects each accepted point,
  // and checks result beats in order.
  class projection_board;
    logic [CfgWidth-1:0]  regs [8];
    screen_pt_t           pending[$];
    int                   errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[CfgWidthR]  = 64'd1920;
      regs[CfgHeightR] = 64'd1080;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgWidth-1:0] val);
      regs[idx] = (idx == CfgWidthR || idx == CfgHeightR) ? val & 64'h3FFF : val;
    endfunction

    // exact clip value: three products plus column 3 scaled to 2F fraction bits
    function wide_t row_dot(logic [63:0] lo, logic [63:0] hi, wide_t px, wide_t py,
                            wide_t pz);
      wide_t c0, c1, c2, c3;
      c0 = $signed(lo[31:0]);
      c1 = $signed(lo[63:32]);
      c2 = $signed(hi[31:0]);
      c3 = $signed(hi[63:32]);
      return c0 * px + c1 * py + c2 * pz + (c3 <<< FracBits);
    endfunction

    // trunc(|c| * size * 2^F / 2w), clamped to 2^62, sign of c restored
    function longint viewport_offset(wide_t c, wide_t w, logic [13:0] size);
      logic [127:0] mag, num, q, den;
      mag = (c < 0) ? -c : c;
      num = (mag * {114'd0, size}) << FracBits;
      den = w << 1;
      q   = num / den;
      if (q > (128'd1 << 62)) q = 128'd1 << 62;
      return (c < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function logic signed [CoordWidth-1:0] clamp_coord(longint v);
      longint top, bot;
      top = (longint'(1) <<< (CoordWidth - 1)) - 1;
      bot = -top - 1;
      if (v > top) return top[CoordWidth-1:0];
      if (v < bot) return bot[CoordWidth-1:0];
      return v[CoordWidth-1:0];
    endfunction

    function void note_point(logic signed [CoordWidth-1:0] x, logic signed [CoordWidth-1:0] y,
                             logic signed [CoordWidth-1:0] z);
      wide_t      px, py, pz, cx, cy, cw;
      logic [13:0] wd, ht;
      longint     sx, sy;
      screen_pt_t e;
      px = x; py = y; pz = z;
      cx = row_dot(regs[CfgRow0Lo], regs[CfgRow0Hi], px, py, pz);
      cy = row_dot(regs[CfgRow1Lo], regs[CfgRow1Hi], px, py, pz);
      cw = row_dot(regs[CfgRowWLo], regs[CfgRowWHi], px, py, pz);
      wd = regs[CfgWidthR][13:0];
      ht = regs[CfgHeightR][13:0];
      // w below 0.001 (or negative): invisible, coordinates zero
      if (cw < 0 || cw * 1000 < (wide_t'(1) <<< (2 * FracBits))) begin
        e = '{1'b0, '0, '0};
      end else begin
        sx = (longint'(wd) <<< (FracBits - 1)) + viewport_offset(cx, cw, wd);
        sy = (longint'(ht) <<< (FracBits - 1)) - viewport_offset(cy, cw, ht);
        e = '{1'b1, clamp_coord(sx), clamp_coord(sy)};
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic vis, logic signed [CoordWidth-1:0] sx,
                               logic signed [CoordWidth-1:0] sy);
      screen_pt_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (vis !== e.vis) begin
        $error("visible: expected %0b actual %0b", e.vis, vis);
        errors++;
      end
      if (sx !== e.sx) begin
        $error("screen_x: expected %0d actual %0d", e.sx, sx);
        errors++;
      end
      if (sy !== e.sy) begin
        $error("screen_y: expected %0d actual %0d", e.sy, sy);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, start, busy;
  logic signed [CoordWidth-1:0] point_x_i, point_y_i, point_z_i;
  logic result_valid_o, visible_o;
  logic signed [CoordWidth-1:0] screen_x_o, screen_y_o;
  logic cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_idx_i;
  logic [CfgWidth-1:0] cfg_data_i;

  projection_board board = new();
  int idle_pct;   // share of cycles, in a hundred, in which the sender idles

  world_to_screen_projection_core dut (.*);

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Monitor: all bench drives past time zero are nonblocking, so these reads see pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note_point(point_x_i, point_y_i, point_z_i);
      if (result_valid_o) board.check_result(visible_o, screen_x_o, screen_y_o);
    end
  end

  // Limit: far beyond the slowest legal run (~1000 beats, gaps, drains).
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Present one point and hold it until the start beat is taken.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start     <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    do @(posedge clk_i); while (busy);
  endtask

  // Let every expected beat come back, then cover the pipeline depth.
  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Write the full register file; only called while the core is empty.
  task automatic load_regs(logic [CfgWidth-1:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= i[CfgIdxWidth-1:0];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      board.set_reg(cfg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly small coefficients (|c| <= span, 4.0 or 0.25 here), sometimes any 32-bit word.
  function automatic logic [31:0] pick_coef(int unsigned span);
    if ($urandom_range(4) == 0) return $urandom;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [31:0] pick_coord();
    if ($urandom_range(4) == 0) return $urandom;
    return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;   // about +/-256.0
  endfunction

  localparam logic [31:0] One = 32'h0001_0000;

  initial begin
    logic [CfgWidth-1:0] cfg [8];
    int unsigned wd, ht;
    rst_ni = 1'b0; start = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    point_x_i = '0; point_y_i = '0; point_z_i = '0;
    idle_pct = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: all-zero matrix, so w is zero and nothing is visible.
    send_point(32'h7FFF_FFFF, 32'h8000_0000, One);
    send_point('0, '0, '0);
    drain();

    // Plain perspective: x' = x, y' = y, w = z, 1920x1080 viewport.
    cfg = '{ {32'd0, One}, 64'd0, {One, 32'd0}, 64'd0, 64'd0, {32'd0, One},
             64'd1920, 64'd1080 };
    load_regs(cfg);
    send_point('0, '0, One);                         // screen center
    send_point(One, One, One);                       // top right corner
    send_point(-One, -One, One);                     // bottom left corner
    send_point(One, '0, '0);                         // w zero: invisible
    send_point(One, One, -One);                      // w negative: invisible
    send_point(One, One, 32'd65);                    // w just below 0.001
    send_point(One, One, 32'd66);                    // w just above 0.001
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd66); // saturates high/low
    send_point(32'h8000_0000, 32'h8000_0000, 32'd66); // saturates the other way
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, One);
    drain();

    // Extreme coefficients and a column 3 bias, viewport at 8192x8192.
    cfg = '{ {32'h8000_0000, 32'h7FFF_FFFF}, {32'h7FFF_FFFF, 32'h8000_0000},
             {32'h7FFF_FFFF, 32'h7FFF_FFFF}, {32'h8000_0000, 32'h0000_0001},
             64'd0, {32'h7FFF_FFFF, 32'd0}, 64'd8192, 64'd8192 };
    load_regs(cfg);
    send_point('0, '0, '0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(One, 32'hFFFF_0000, 32'h0000_8000);
    drain();

    // Random phases: fresh matrix and viewport each time, varied sender gaps.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  wd = 1;     ht = 8192; end
        1: begin idle_pct = 64; wd = 8192;  ht = 1;    end
        2: begin idle_pct = 0;  wd = 0;     ht = 0;    end   // zero-size viewport
        3: begin idle_pct = 24; wd = $urandom_range(1, 8192); ht = $urandom_range(1, 8192); end
        4: begin idle_pct = 64; wd = 640;   ht = 480;  end
        default: begin idle_pct = 24; wd = $urandom_range(16383); ht = $urandom; end
      endcase
      for (int r = 0; r < 2; r++) begin
        cfg[2*r]   = {pick_coef(32'h0004_0000), pick_coef(32'h0004_0000)};
        cfg[2*r+1] = {pick_coef(32'h0004_0000), pick_coef(32'h0004_0000)};
      end
      // keep w mostly positive so most points are visible
      cfg[CfgRowWLo] = {pick_coef(32'h0000_4000), pick_coef(32'h0000_4000)};
      cfg[CfgRowWHi] = {32'($urandom_range(One, 64 * One)), pick_coef(32'h0000_4000)};
      if (ph == 5) cfg[CfgRowWHi] = {$urandom, $urandom};
      cfg[CfgWidthR]  = 64'(wd);
      cfg[CfgHeightR] = {$urandom, 32'(ht)};
      load_regs(cfg);
      for (int n = 0; n < 150; n++) begin
        send_point(pick_coord(), pick_coord(), pick_coord());
        // hold off once per phase until the pipeline has emptied
        if (n == 75) begin
          start <= 1'b0;
          while (board.pending.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
sv/wpp_pkg.sv
sv/world_to_screen_projection_core.sv
sv/wpp_checker.sv
bench/world_to_screen_projection_core_test.sv
